### hdl/gdc_pkg.sv
// Shared types, constants and command structs for the gamepad dead-zone conditioner.
`default_nettype none

package gdc_pkg;

  localparam int FRAC_BITS   = 15;
  localparam int ROOT_STEPS  = 31;
  localparam int DIV_STEPS   = 17;
  localparam int CNT_W       = 5;
  localparam int NUM_W       = 47;
  localparam int ROOT_W      = 31;

  localparam logic [14:0] STICK_FULL = 15'd32767;
  localparam logic [7:0]  TRIG_FULL  = 8'd255;
  localparam logic [15:0] ONE_Q15    = 16'h8000;
  localparam logic [15:0] POS_MAX    = 16'h7FFF;
  localparam logic [15:0] NEG_MIN    = 16'h8000;

  localparam logic [1:0] REG_LEFT_STICK_DZ  = 2'd0;
  localparam logic [1:0] REG_RIGHT_STICK_DZ = 2'd1;
  localparam logic [1:0] REG_LEFT_TRIG_DZ   = 2'd2;
  localparam logic [1:0] REG_RIGHT_TRIG_DZ  = 2'd3;

  typedef enum logic [2:0] {
    JOB_LMAG, JOB_LX, JOB_LY, JOB_RMAG, JOB_RX, JOB_RY, JOB_LT, JOB_RT
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_SUM, ST_ROOT, ST_DLOAD, ST_DIV, ST_STORE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic sum;
    logic root_step;
    logic div_load;
    logic div_step;
    logic store;
    logic publish;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### hdl/gdc_ctrl.sv
// Controller state machine that sequences squaring, root and division steps.
`default_nettype none

module gdc_ctrl
  import gdc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;
  job_t job, job_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= JOB_LMAG;
      cnt   <= '0;
    end else begin
      state <= state_next;
      job   <= job_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.job    = job;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          job_next   = JOB_LMAG;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        cnt_next   = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        unique case (job)
          JOB_LY: begin
            job_next   = JOB_RMAG;
            state_next = ST_SQ;
          end
          JOB_RT: begin
            state_next = ST_OUT;
          end
          default: begin
            job_next   = job_t'(job + 3'd1);
            state_next = ST_DLOAD;
          end
        endcase
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/gdc_datapath.sv
// Datapath: sample capture, squares, bit-serial root and divider, result registers.
`default_nettype none

module gdc_datapath
  import gdc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cmd_t         cmd,
  output status_t           status,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [14:0]  cfg_data,
  input  wire logic [95:0]  in_data,
  input  wire logic         in_conn,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [175:0]      out_data
);

  // Configuration registers.
  logic [14:0] lsdz, rsdz;
  logic [7:0]  ltdz, rtdz;

  always_ff @(posedge clk) begin
    if (rst) begin
      lsdz <= 15'd7849;
      rsdz <= 15'd8689;
      ltdz <= 8'd30;
      rtdz <= 8'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_STICK_DZ:  lsdz <= cfg_data;
        REG_RIGHT_STICK_DZ: rsdz <= cfg_data;
        REG_LEFT_TRIG_DZ:   ltdz <= cfg_data[7:0];
        REG_RIGHT_TRIG_DZ:  rtdz <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Captured sample.
  logic               conn;
  logic signed [15:0] lx, ly, rx, ry;
  logic [7:0]         lt, rt;
  logic [15:0]        btn;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      conn <= in_conn;
      lx   <= in_data[15:0];
      ly   <= in_data[31:16];
      rx   <= in_data[47:32];
      ry   <= in_data[63:48];
      lt   <= in_data[71:64];
      rt   <= in_data[79:72];
      btn  <= in_data[95:80];
    end
  end

  logic               right_side;
  logic signed [15:0] sx, sy;
  logic [14:0]        sdz;

  always_comb begin
    unique case (cmd.job)
      JOB_RMAG, JOB_RX, JOB_RY: right_side = 1'b1;
      default:                  right_side = 1'b0;
    endcase
    sx  = right_side ? rx : lx;
    sy  = right_side ? ry : ly;
    sdz = right_side ? rsdz : lsdz;
  end

  // Squares, each product registered.
  logic signed [31:0] px, py;
  logic [30:0]        xx, yy;
  logic [29:0]        dd;
  logic [31:0]        ssum;
  logic               in_zone;

  assign px = sx * sx;
  assign py = sy * sy;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      xx <= px[30:0];
      yy <= py[30:0];
      dd <= sdz * sdz;
    end
  end

  assign ssum = {1'b0, xx} + {1'b0, yy};

  // Bit-serial square root of (x^2 + y^2) << 30, two radicand bits per step.
  logic [61:0]       vsh;
  logic [32:0]       rem;
  logic [ROOT_W-1:0] root;
  logic [34:0]       rem_sh, rsub;
  logic              rok;

  assign rem_sh = {rem, vsh[61:60]};
  assign rsub   = {2'b00, root, 2'b01};
  assign rok    = rem_sh >= rsub;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      in_zone <= ssum <= {2'b00, dd};
      vsh     <= {ssum, 30'd0};
      rem     <= '0;
      root    <= '0;
    end else if (cmd.root_step) begin
      vsh  <= {vsh[59:0], 2'b00};
      rem  <= rok ? 33'(rem_sh - rsub) : rem_sh[32:0];
      root <= {root[ROOT_W-2:0], rok};
    end
  end

  // Division setup for the current job.
  localparam logic [ROOT_W-1:0] CAP = ROOT_W'(32'd32767 << FRAC_BITS);

  logic               is_dir, is_trig;
  logic signed [15:0] dv;
  logic [16:0]        dabs;
  logic [ROOT_W-1:0]  rc;
  logic [14:0]        sden;
  logic [7:0]         tv, tdz, tden;
  logic [NUM_W-1:0]   num;
  logic [ROOT_W-1:0]  dsor;
  logic               zero_ld, one_ld;

  always_comb begin
    unique case (cmd.job)
      JOB_LX, JOB_RX, JOB_LY, JOB_RY: is_dir = 1'b1;
      default:                        is_dir = 1'b0;
    endcase
    unique case (cmd.job)
      JOB_LT, JOB_RT: is_trig = 1'b1;
      default:        is_trig = 1'b0;
    endcase
    unique case (cmd.job)
      JOB_LY, JOB_RY: dv = sy;
      default:        dv = sx;
    endcase
    dabs = dv[15] ? 17'(-{dv[15], dv}) : {1'b0, dv};
    rc   = (root > CAP) ? CAP : root;
    sden = STICK_FULL - sdz;
    tv   = (cmd.job == JOB_RT) ? rt : lt;
    tdz  = (cmd.job == JOB_RT) ? rtdz : ltdz;
    tden = TRIG_FULL - tdz;
    if (is_trig) begin
      num     = NUM_W'({tv - tdz, 15'd0}) + NUM_W'(tden >> 1);
      dsor    = ROOT_W'(tden);
      zero_ld = tv < tdz;
      one_ld  = tden == 8'd0;
    end else if (is_dir) begin
      num     = NUM_W'({dabs, 30'd0}) + NUM_W'(root >> 1);
      dsor    = root;
      zero_ld = in_zone;
      one_ld  = 1'b0;
    end else begin
      num     = NUM_W'(rc) - NUM_W'({sdz, 15'd0}) + NUM_W'(sden >> 1);
      dsor    = ROOT_W'(sden);
      zero_ld = in_zone;
      one_ld  = sden == 15'd0;
    end
  end

  // Restoring divider, one quotient bit per step.
  logic [31:0]           drem, dsh;
  logic [DIV_STEPS-1:0]  nlo, quot;
  logic [ROOT_W-1:0]     divr;
  logic                  dok, neg, zero_f, one_f;

  assign dsh = {drem[30:0], nlo[DIV_STEPS-1]};
  assign dok = dsh >= {1'b0, divr};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      drem   <= 32'(num[NUM_W-1:DIV_STEPS]);
      nlo    <= num[DIV_STEPS-1:0];
      quot   <= '0;
      divr   <= dsor;
      neg    <= dv[15];
      zero_f <= zero_ld;
      one_f  <= one_ld;
    end else if (cmd.div_step) begin
      drem <= dok ? dsh - {1'b0, divr} : dsh;
      nlo  <= {nlo[DIV_STEPS-2:0], 1'b0};
      quot <= {quot[DIV_STEPS-2:0], dok};
    end
  end

  logic [15:0] val;

  always_comb begin
    if (zero_f) begin
      val = '0;
    end else if (one_f) begin
      val = ONE_Q15;
    end else if (is_dir) begin
      if (neg) begin
        val = (quot > 17'd32768) ? NEG_MIN : 16'(-quot);
      end else begin
        val = (quot > 17'd32767) ? POS_MAX : quot[15:0];
      end
    end else begin
      val = quot[16] ? 16'hFFFF : quot[15:0];
    end
  end

  logic [15:0] res [8];

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      res[cmd.job] <= val;
    end
  end

  // Output register and button history.
  logic [15:0] prev, now;

  assign now             = conn ? btn : 16'd0;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev      <= '0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
      prev      <= now;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data[127:0] <= conn ? {res[7], res[6], res[5], res[4],
                                 res[3], res[2], res[1], res[0]} : 128'd0;
      out_data[143:128] <= now;
      out_data[159:144] <= now & ~prev;
      out_data[175:160] <= prev & ~now;
    end
  end

endmodule

`default_nettype wire

### hdl/gamepad_deadzone_conditioner.sv
// Top level of the gamepad dead-zone conditioner: controller plus datapath.
`default_nettype none

// The block takes one polled gamepad sample per request on the s_axis channel
// and returns one conditioned request on the m_axis channel. For each stick it
// applies a circular dead zone and gives a Q1.15 magnitude and unit direction;
// each trigger is thresholded and rescaled, and the button word is compared
// with the previous sample to give held, rising and falling masks.
// Work is sequential: a single bit-serial root unit (31 steps) serves both
// sticks, and a single restoring divider (17 steps) is shared by both sticks
// and both triggers, so a new sample is taken only after the last one has
// been handed to the output register.
// s_axis_tready is high only while no sample is being worked on. A finished
// request sits in the output register; the next sample is still accepted and
// worked on while the receiver stalls, and its results wait until the output
// register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. Reset restores the default dead zones, clears the
// previous button word and empties the output register.

module gamepad_deadzone_conditioner
  import gdc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // left_stick_x, left_stick_y, right_stick_x, right_stick_y,
  // left_trigger_raw, right_trigger_raw, buttons_now
  input  wire logic [95:0]  s_axis_tdata,
  // connected
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // left_magnitude, left_dir_x, left_dir_y, right_magnitude, right_dir_x,
  // right_dir_y, left_trigger_level, right_trigger_level, buttons_held,
  // button_rises, button_falls
  output logic [175:0]      m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [14:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  gdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gdc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_conn   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // A sample in flight blocks the next one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second sample accepted while one is in flight");

  // A button cannot rise and fall in the same sample.
  a_rise_fall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[159:144] & m_axis_tdata[175:160]) == 16'd0))
    else $error("button both rising and falling");

  // Rising buttons are a subset of held buttons.
  a_rise_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[159:144] & ~m_axis_tdata[143:128]) == 16'd0))
    else $error("rising button not held");

  // Left stick magnitude never exceeds full scale.
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= ONE_Q15))
    else $error("left magnitude beyond full scale");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the gamepad dead-zone conditioner.
`timescale 1ns / 100ps

// Scoreboard: holds the expected conditioned outputs in request order and
// compares each result request field by field against the oldest one.
class deadzone_scoreboard;
  logic [175:0] pending_outputs[$];
  int mismatch_count;
  int checked_count;

  function void note_request(logic [175:0] predicted);
    pending_outputs.push_back(predicted);
  endfunction

  function void check_result(logic [175:0] actual);
    logic [175:0] want;
    int f;
    bit bad;
    if (pending_outputs.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("ERROR: unexpected result %h", actual);
      return;
    end
    want = pending_outputs.pop_front();
    checked_count++;
    bad = 0;
    for (f = 0; f < 11; f++) begin
      if (want[f*16 +: 16] !== actual[f*16 +: 16]) bad = 1;
    end
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        for (f = 0; f < 11; f++) begin
          if (want[f*16 +: 16] !== actual[f*16 +: 16])
            $display("ERROR: result %0d field %0d expected %h got %h",
                     checked_count, f, want[f*16 +: 16], actual[f*16 +: 16]);
        end
      end
    end
  endfunction
endclass

module testbench;
  import gdc_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [175:0] m_axis_tdata;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = REG_LEFT_STICK_DZ;
  logic [14:0]  cfg_data = '0;

  gamepad_deadzone_conditioner DUT (.*);

  always #5 clk = ~clk;

  // Predictor state: its own copy of the dead zones and the previous buttons.
  logic [14:0] left_radius, right_radius;
  logic [7:0]  left_threshold, right_threshold;
  logic [15:0] last_buttons;

  deadzone_scoreboard board = new();
  int sent_count;
  int stall_cycles_left;
  bit sender_done;

  // Integer square root of a value up to 62 bits wide.
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Rounded unit-direction component, saturated to the signed Q1.15 range.
  function automatic logic [15:0] unit_component(logic signed [15:0] v, logic [63:0] r);
    logic [63:0] mag, q;
    mag = v < 0 ? 64'(-32'(v)) : 64'(v);
    q = ((mag << (2 * FRAC_BITS)) + r / 2) / r;
    if (v < 0) return q > 32768 ? NEG_MIN : 16'(-q);
    return q > 32767 ? POS_MAX : 16'(q);
  endfunction

  // Magnitude and direction of one stick under a circular dead zone.
  function automatic logic [47:0] stick_outputs(logic signed [15:0] x,
                                                logic signed [15:0] y,
                                                logic [14:0] dz);
    logic [63:0] sq, r, capped, num, den, mag;
    sq = 64'(32'(x) * 32'(x)) + 64'(32'(y) * 32'(y));
    if (sq <= 64'(dz) * 64'(dz)) return '0;
    r = isqrt(sq << (2 * FRAC_BITS));
    capped = r > (64'(STICK_FULL) << FRAC_BITS) ? (64'(STICK_FULL) << FRAC_BITS) : r;
    num = capped - (64'(dz) << FRAC_BITS);
    den = 64'(STICK_FULL) - 64'(dz);
    mag = den == 0 ? 64'(ONE_Q15) : (num + den / 2) / den;
    if (mag > 65535) mag = 65535;
    return {unit_component(y, r), unit_component(x, r), mag[15:0]};
  endfunction

  function automatic logic [15:0] trigger_level(logic [7:0] raw, logic [7:0] dz);
    logic [63:0] den, q;
    if (raw < dz) return 0;
    den = 64'(TRIG_FULL) - 64'(dz);
    if (den == 0) return ONE_Q15;
    q = ((64'(raw - dz) << FRAC_BITS) + den / 2) / den;
    return q > 65535 ? 16'hFFFF : q[15:0];
  endfunction

  // Expected result request for one sample; also advances the button history.
  function automatic logic [175:0] condition_sample(logic conn, logic [95:0] d);
    logic [175:0] o;
    logic [15:0] now;
    o = '0;
    now = conn ? d[95:80] : 16'h0;
    if (conn) begin
      o[47:0]    = stick_outputs(d[15:0], d[31:16], left_radius);
      o[95:48]   = stick_outputs(d[47:32], d[63:48], right_radius);
      o[111:96]  = trigger_level(d[71:64], left_threshold);
      o[127:112] = trigger_level(d[79:72], right_threshold);
    end
    o[143:128] = now;
    o[159:144] = now & ~last_buttons;
    o[175:160] = last_buttons & ~now;
    last_buttons = now;
    return o;
  endfunction

  // Offers one sample after a random gap (none with no_gap) and waits until it is taken.
  // The request line stays up on return; drain() or a next call with a gap lowers it.
  task automatic send_sample(logic conn, logic [95:0] d, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= conn;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(condition_sample(conn, d));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [14:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_LEFT_STICK_DZ:  left_radius = val;
      REG_RIGHT_STICK_DZ: right_radius = val;
      REG_LEFT_TRIG_DZ:   left_threshold = val[7:0];
      default:            right_threshold = val[7:0];
    endcase
  endtask

  // Waits until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random stick value: often an extreme or near the center, else anything.
  function automatic logic [15:0] stick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [95:0] random_sample();
    logic [95:0] d;
    d[15:0] = stick_value();
    d[31:16] = stick_value();
    d[47:32] = stick_value();
    d[63:48] = stick_value();
    d[79:64] = 16'($urandom);
    d[95:80] = 16'($urandom);
    return d;
  endfunction

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering samples so that the block fills up and stops accepting.
  initial begin
    int wait_cycles;
    stall_cycles_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_cycles_left > 0) begin
        m_axis_tready <= 0;
        stall_cycles_left--;
        @(negedge clk);
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (wait_cycles > 0) begin
          m_axis_tready <= 0;
          repeat (wait_cycles) @(negedge clk);
        end
        m_axis_tready <= 1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Stimulus: directed corners, then random phases under several settings.
  initial begin
    logic [95:0] d;
    int p, k;
    logic [14:0] stick_dz [6] = '{0, 32766, 1, 7849, 20000, 300};
    logic [7:0]  trig_dz  [6] = '{0, 254, 1, 30, 128, 200};
    left_radius = 7849;
    right_radius = 8689;
    left_threshold = 30;
    right_threshold = 30;
    last_buttons = 0;
    sent_count = 0;
    sender_done = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: stick corners, centered and just past the dead zone, trigger
    // extremes, button edges and a disconnected sample.
    send_sample(1, {16'hFFFF, 8'd255, 8'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
    send_sample(1, {16'h0000, 8'd0, 8'd255, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
    send_sample(1, {16'h00FF, 8'd30, 8'd29, 16'd0, 16'd8690, 16'd0, 16'd7850});
    send_sample(1, {16'hFF00, 8'd31, 8'd30, 16'd6144, 16'd6144, 16'd0, 16'd7849});
    send_sample(1, {16'h0F0F, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_sample(0, {16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_sample(1, {16'h8001, 8'd100, 8'd200, 16'h8000, 16'd0, 16'd0, 16'h8000});
    send_sample(1, {16'h0001, 8'd128, 8'd128, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF});
    drain();

    // Full-scale dead zones: the span is zero, so outside means 1.0.
    write_register(REG_LEFT_STICK_DZ, 15'd32767);
    write_register(REG_RIGHT_STICK_DZ, 15'd32767);
    write_register(REG_LEFT_TRIG_DZ, 15'd255);
    write_register(REG_RIGHT_TRIG_DZ, 15'd255);
    send_sample(1, {16'h1234, 8'd255, 8'd254, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
    send_sample(1, {16'h0000, 8'd254, 8'd255, 16'd0, 16'h7FFF, 16'h8000, 16'd0});
    send_sample(1, {16'hFFFF, 8'd255, 8'd255, 16'd100, 16'd32767, 16'd5, 16'h8001});
    drain();

    // Random phases, one per dead-zone setting.
    for (p = 0; p < 6; p++) begin
      write_register(REG_LEFT_STICK_DZ, stick_dz[p]);
      write_register(REG_RIGHT_STICK_DZ, stick_dz[5 - p]);
      write_register(REG_LEFT_TRIG_DZ, {7'd0, trig_dz[p]});
      write_register(REG_RIGHT_TRIG_DZ, {7'd0, trig_dz[5 - p]});
      for (k = 0; k < 220; k++) begin
        if (p == 2 && k == 50) stall_cycles_left = 1500;
        d = random_sample();
        send_sample($urandom_range(0, 9) != 0, d, p == 2 && k >= 50 && k < 60);
      end
      drain();
    end
    sender_done = 1;
  end

  initial begin
    wait (sender_done);
    repeat (300) @(posedge clk);
    $display("Run covered %0d samples, %0d results checked, 8 dead-zone settings.",
             sent_count, board.checked_count);
    $display("Stick extremes, zero-span dead zones, disconnects and a long stall done.");
    if (board.mismatch_count == 0 && board.pending_outputs.size() == 0) begin
      $display("PASS gamepad_deadzone_conditioner");
    end else begin
      $display("FAIL gamepad_deadzone_conditioner");
    end
    $finish;
  end

  // Worst case: about 1350 samples plus gaps and stalls.
  initial begin
    #20_000_000;
    $display("ERROR: timeout with %0d results pending", board.pending_outputs.size());
    $display("FAIL gamepad_deadzone_conditioner");
    $finish;
  end
endmodule

### files.f
hdl/gdc_pkg.sv
hdl/gdc_ctrl.sv
hdl/gdc_datapath.sv
hdl/gamepad_deadzone_conditioner.sv
test/testbench.sv
